// ----- rtl/glf_pkg.sv -----
package glf_pkg;

  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;
  localparam int LN_W      = 27;
  localparam int MAX_POS   = 9;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_EOL  = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_DEL   = 8'h80;

  function automatic logic [LN_W-1:0] pow10(input logic [3:0] pos);
    logic [LN_W-1:0] p;
    case (pos)
      4'd0:    p = 27'd1;
      4'd1:    p = 27'd10;
      4'd2:    p = 27'd100;
      4'd3:    p = 27'd1000;
      4'd4:    p = 27'd10000;
      4'd5:    p = 27'd100000;
      4'd6:    p = 27'd1000000;
      4'd7:    p = 27'd10000000;
      4'd8:    p = 27'd100000000;
      default: p = 27'd1;
    endcase
    return p;
  endfunction

  function automatic logic [LN_W:0] number_limit(input int digits);
    longint lim;
    lim = 1;
    for (int i = 0; i < digits && i < 10; i++) begin
      lim = lim * 10;
    end
    if (lim > (longint'(1) << LN_W)) begin
      lim = longint'(1) << LN_W;
    end
    return lim[LN_W:0];
  endfunction

endpackage

// ----- rtl/gcode_line_framer_core.sv -----
// Frames G-code source lines as "N<number><text>*<xor checksum>\n". Input items carry a
// command in s_axis_tuser_i (0 source byte, 1 end of line, 2 load line number); output items
// are single bytes with tlast on the final byte caused by an input item and tuser set when
// a pending run of trimmable bytes overflowed the store in the current line. A source byte
// that is held, dropped or a comment, an unused command and an empty end of line emit nothing.
// A printable byte flushes the stored bytes and is then emitted; the first printable byte of a
// line is preceded by 'N' and the line number, whose NUMBER_DIGITS digit positions (at most
// nine) are each found by subtracting that power of ten once per unit of the digit. End of
// line emits '*', the checksum over its three digit positions found the same way, and '\n'.
// A line number load reduces the number, for each digit position from the ninth down to the
// one above NUMBER_DIGITS, by subtracting that power of ten as often as it fits. These steps
// use the single shared compare-and-subtract unit that peels off powers of ten, the store of
// pending bytes, and the output register; a stalled output stretches every emitting step.
// The block takes no new item until the current one is finished.
module gcode_line_framer_core #(
  parameter int SPACE_DEPTH   = 32,
  parameter int NUMBER_DIGITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // data_byte [7:0], new_line_number [34:8], zero fill
  input  logic [glf_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd [1:0]
  input  logic [glf_pkg::S_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // out_byte [7:0]
  output logic [glf_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  // space_overflow [0]
  output logic                           m_axis_tuser_o
);
  import glf_pkg::*;

  localparam int AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
  localparam int CW = $clog2(SPACE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SPACE_DEPTH);
  localparam int NUM_POS = (NUMBER_DIGITS < MAX_POS) ? NUMBER_DIGITS : MAX_POS;
  localparam logic [3:0] TOP_POS  = 4'(NUM_POS - 1);
  localparam logic [3:0] MOD_STOP = 4'(NUM_POS);
  localparam logic [3:0] MOD_TOP  = 4'(MAX_POS - 1);
  localparam bit NEED_MOD = (NUMBER_DIGITS < MAX_POS);
  localparam logic [LN_W:0] LIMIT = number_limit(NUMBER_DIGITS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PRE_N  = 4'd1;
  localparam logic [3:0] ST_DIG    = 4'd2;
  localparam logic [3:0] ST_FL_CHK = 4'd3;
  localparam logic [3:0] ST_FL_EM  = 4'd4;
  localparam logic [3:0] ST_BYTE   = 4'd5;
  localparam logic [3:0] ST_STAR   = 4'd6;
  localparam logic [3:0] ST_NL     = 4'd7;
  localparam logic [3:0] ST_MOD    = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [LN_W-1:0] line_q, line_d;
  logic [7:0]      xor_q, xor_d;
  logic            comment_q, comment_d;
  logic            prefix_q, prefix_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic            ovf_q, ovf_d;
  logic [7:0]      byte_q, byte_d;
  logic [LN_W-1:0] val_q, val_d;
  logic [3:0]      pos_q, pos_d;
  logic [3:0]      dig_q, dig_d;
  logic            started_q, started_d;
  logic            csum_q, csum_d;

  logic            out_valid_q;
  logic [7:0]      out_data_q;
  logic            out_last_q;
  logic            out_user_q;

  logic [7:0]      mem_q [SPACE_DEPTH];
  logic [7:0]      rd_q;
  logic            mem_we;

  logic            accept;
  logic            out_free;
  logic            emit_en;
  logic [7:0]      emit_byte;
  logic            emit_last;
  logic [LN_W:0]   diff;
  logic            ge;
  logic [1:0]      cmd;
  logic [7:0]      in_byte;
  logic            trimmable;
  logic [LN_W:0]   line_inc;

  assign cmd       = s_axis_tuser_i;
  assign in_byte   = s_axis_tdata_i[7:0];
  assign trimmable = (in_byte <= CH_SPACE) || (in_byte >= CH_DEL);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // shared compare and subtract unit
  assign diff = {1'b0, val_q} - {1'b0, pow10(pos_q)};
  assign ge   = !diff[LN_W];
  assign line_inc = {1'b0, line_q} + {{LN_W{1'b0}}, 1'b1};

  assign mem_we = accept && (cmd == CMD_BYTE) && !comment_q && (in_byte != CH_SEMI) &&
                  trimmable && (cnt_q < DEPTH_C);

  always_comb begin
    state_d   = state_q;
    line_d    = line_q;
    xor_d     = xor_q;
    comment_d = comment_q;
    prefix_d  = prefix_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    byte_d    = byte_q;
    val_d     = val_q;
    pos_d     = pos_q;
    dig_d     = dig_q;
    started_d = started_q;
    csum_d    = csum_q;
    emit_en   = 1'b0;
    emit_byte = 8'h00;
    emit_last = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = '0;
          case (cmd)
            CMD_BYTE: begin
              if (!comment_q) begin
                if (in_byte == CH_SEMI) begin
                  comment_d = 1'b1;
                end else if (trimmable) begin
                  if (cnt_q < DEPTH_C) begin
                    cnt_d = cnt_q + 1'b1;
                  end else begin
                    ovf_d = 1'b1;
                  end
                end else begin
                  byte_d  = in_byte;
                  state_d = prefix_q ? ST_FL_CHK : ST_PRE_N;
                end
              end
            end
            CMD_EOL: begin
              if (prefix_q) begin
                state_d = ST_STAR;
              end else begin
                xor_d     = 8'h00;
                comment_d = 1'b0;
                cnt_d     = '0;
                ovf_d     = 1'b0;
              end
            end
            CMD_LOAD: begin
              if (NEED_MOD) begin
                val_d   = s_axis_tdata_i[LN_W+7:8];
                pos_d   = MOD_TOP;
                state_d = ST_MOD;
              end else begin
                line_d = s_axis_tdata_i[LN_W+7:8];
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOD: begin
        if (ge) begin
          val_d = diff[LN_W-1:0];
        end else if (pos_q == MOD_STOP) begin
          line_d  = val_q;
          state_d = ST_IDLE;
        end else begin
          pos_d = pos_q - 1'b1;
        end
      end
      ST_PRE_N: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_byte = CH_N;
          val_d     = line_q;
          pos_d     = TOP_POS;
          dig_d     = '0;
          started_d = 1'b0;
          csum_d    = 1'b0;
          state_d   = ST_DIG;
        end
      end
      ST_DIG: begin
        if (ge) begin
          val_d = diff[LN_W-1:0];
          dig_d = dig_q + 1'b1;
        end else if ((dig_q != 4'd0) || started_q || (pos_q == 4'd0)) begin
          if (out_free) begin
            emit_en   = 1'b1;
            emit_byte = CH_ZERO + {4'd0, dig_q};
            started_d = 1'b1;
            dig_d     = '0;
            if (pos_q == 4'd0) begin
              if (csum_q) begin
                state_d = ST_NL;
              end else begin
                prefix_d = 1'b1;
                state_d  = ST_FL_CHK;
              end
            end else begin
              pos_d = pos_q - 1'b1;
            end
          end
        end else begin
          pos_d = pos_q - 1'b1;
        end
      end
      ST_FL_CHK: begin
        if (idx_q != cnt_q) begin
          state_d = ST_FL_EM;
        end else begin
          cnt_d   = '0;
          state_d = ST_BYTE;
        end
      end
      ST_FL_EM: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_byte = rd_q;
          idx_d     = idx_q + 1'b1;
          state_d   = ST_FL_CHK;
        end
      end
      ST_BYTE: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_byte = byte_q;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_STAR: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_byte = CH_STAR;
          val_d     = {{(LN_W-8){1'b0}}, xor_q};
          pos_d     = 4'd2;
          dig_d     = '0;
          started_d = 1'b0;
          csum_d    = 1'b1;
          state_d   = ST_DIG;
        end
      end
      ST_NL: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_byte = CH_NL;
          emit_last = 1'b1;
          line_d    = (line_inc >= LIMIT) ? '0 : line_inc[LN_W-1:0];
          comment_d = 1'b0;
          prefix_d  = 1'b0;
          cnt_d     = '0;
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit_en) begin
      xor_d = xor_q ^ emit_byte;
    end
    if (state_q == ST_NL && emit_en) begin
      xor_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      line_q      <= '0;
      xor_q       <= '0;
      comment_q   <= 1'b0;
      prefix_q    <= 1'b0;
      cnt_q       <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      dig_q       <= '0;
      started_q   <= 1'b0;
      csum_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      line_q    <= line_d;
      xor_q     <= xor_d;
      comment_q <= comment_d;
      prefix_q  <= prefix_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      ovf_q     <= ovf_d;
      pos_q     <= pos_d;
      dig_q     <= dig_d;
      started_q <= started_d;
      csum_q    <= csum_d;
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    val_q  <= val_d;
    if (emit_en) begin
      out_data_q <= emit_byte;
      out_last_q <= emit_last;
      out_user_q <= ovf_q;
    end
  end

  // pending byte store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[AW-1:0]] <= in_byte;
    end
    rd_q <= mem_q[idx_q[AW-1:0]];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ----- dv/gcode_line_framer_core_tb.sv -----
`timescale 1ns / 100ps
module gcode_line_framer_core_tb;
  import glf_pkg::*;

  localparam int SPACE_DEPTH = 32;
  localparam int NUMBER_DIGITS = 8;
  // 10**NUMBER_DIGITS, capped at 2**27
  localparam longint LINE_NO_WRAP = longint'(number_limit(NUMBER_DIGITS));
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int TIMEOUT_CYCLES = 1_000_000;
  localparam int RAND_ITEMS = 120;
  localparam int TAIL_CYCLES = 200;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       ovf;
  } out_byte_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [7:0]      ch;
    logic [LN_W-1:0] ln;
    logic [7:0]      reps;
    logic            gold_en;
    logic [3:0]      n_gold;
    logic [63:0]     gold;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                 s_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic                 m_tready = 1'b0;
  wire                  s_tready;
  wire                  m_tvalid;
  wire [M_TDATA_W-1:0]  m_tdata;
  wire                  m_tlast;
  wire                  m_tuser;

  int src_idle_pct = 30;
  int snk_idle_pct = 71;
  int errors = 0;
  int items_done = 0;
  int cycles = 0;

  // predicted line state
  logic [LN_W-1:0] ln_now = '0;
  logic [7:0]      sum_now = '0;
  bit              in_comment_now = 1'b0;
  bit              prefix_done = 1'b0;
  bit              run_ovf = 1'b0;
  logic [7:0]      run_buf [SPACE_DEPTH];
  int              run_len = 0;

  out_byte_t bytes_due[$];
  out_byte_t step_bytes[$];

  stim_row_t stim_rows [25] = '{
    '{CMD_BYTE, "G",     '0,             8'd1,  1'b1, 4'd3, "N0G"},
    '{CMD_BYTE, "1",     '0,             8'd1,  1'b1, 4'd1, "1"},
    '{CMD_EOL,  8'h00,   '0,             8'd1,  1'b1, 4'd3, "*8\n"},
    '{CMD_EOL,  8'h00,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_NONE, 8'h00,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_LOAD, 8'h00,   27'd99999999,   8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h00,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, 8'hFF,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h0A,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h0D,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h80,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h20,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h21,   '0,             8'd1,  1'b0, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h7F,   '0,             8'd1,  1'b0, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h20,   '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, CH_SEMI, '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, "X",     '0,             8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_EOL,  8'h00,   '0,             8'd1,  1'b0, 4'd0, 64'd0},
    '{CMD_LOAD, 8'h00,   27'h7FFFFFF,    8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, 8'h09,   '0,             8'd40, 1'b1, 4'd0, 64'd0},
    '{CMD_BYTE, "M",     '0,             8'd1,  1'b0, 4'd0, 64'd0},
    '{CMD_LOAD, 8'h00,   27'd5,          8'd1,  1'b1, 4'd0, 64'd0},
    '{CMD_EOL,  8'h00,   '0,             8'd1,  1'b0, 4'd0, 64'd0},
    '{CMD_BYTE, "Z",     '0,             8'd1,  1'b1, 4'd3, "N6Z"},
    '{CMD_EOL,  8'h00,   '0,             8'd1,  1'b0, 4'd0, 64'd0}
  };

  gcode_line_framer_core #(
    .SPACE_DEPTH   (SPACE_DEPTH),
    .NUMBER_DIGITS (NUMBER_DIGITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void put_byte(logic [7:0] c);
    out_byte_t ob;
    ob.ch = c;
    ob.last = 1'b0;
    ob.ovf = run_ovf;
    step_bytes.push_back(ob);
    sum_now ^= c;
  endfunction

  function automatic void put_decimal(longint v);
    logic [7:0] digs [12];
    int k;
    k = 0;
    do begin
      digs[k] = CH_ZERO + 8'(v % 10);
      v = v / 10;
      k++;
    end while (v != 0);
    for (int i = k - 1; i >= 0; i--) put_byte(digs[i]);
  endfunction

  function automatic void frame_step(logic [1:0] cmd, logic [7:0] b, logic [LN_W-1:0] ln);
    out_byte_t ob;
    logic [7:0] csum;
    longint nxt;
    step_bytes.delete();
    case (cmd)
      CMD_BYTE: begin
        if (!in_comment_now) begin
          if (b == CH_SEMI) begin
            in_comment_now = 1'b1;
          end else if (b <= CH_SPACE || b >= CH_DEL) begin
            if (run_len < SPACE_DEPTH) begin
              run_buf[run_len] = b;
              run_len++;
            end else begin
              run_ovf = 1'b1;
            end
          end else begin
            if (!prefix_done) begin
              put_byte(CH_N);
              put_decimal(longint'(ln_now));
              prefix_done = 1'b1;
            end
            for (int i = 0; i < run_len; i++) put_byte(run_buf[i]);
            run_len = 0;
            put_byte(b);
          end
        end
      end
      CMD_EOL: begin
        if (prefix_done) begin
          csum = sum_now;
          put_byte(CH_STAR);
          put_decimal(longint'(csum));
          put_byte(CH_NL);
          nxt = longint'(ln_now) + 1;
          if (nxt >= LINE_NO_WRAP) nxt = 0;
          ln_now = LN_W'(nxt);
        end
        sum_now = '0;
        in_comment_now = 1'b0;
        prefix_done = 1'b0;
        run_len = 0;
        run_ovf = 1'b0;
      end
      CMD_LOAD: ln_now = LN_W'(longint'(ln) % LINE_NO_WRAP);
      default: ;
    endcase
    if (step_bytes.size() != 0) begin
      ob = step_bytes.pop_back();
      ob.last = 1'b1;
      step_bytes.push_back(ob);
    end
  endfunction

  task automatic issue(input logic [1:0] cmd, input logic [7:0] b, input logic [LN_W-1:0] ln,
                       input bit gold_en, input int n_gold, input logic [63:0] gold);
    out_byte_t ob;
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {{(S_TDATA_W - 8 - LN_W){1'b0}}, ln, b};
    do @(posedge clk_i); while (!s_tready);
    items_done++;
    frame_step(cmd, b, ln);
    if (gold_en) begin
      step_bytes.delete();
      for (int i = 0; i < n_gold; i++) begin
        ob.ch = gold[8*(n_gold-1-i) +: 8];
        ob.last = (i == n_gold - 1);
        ob.ovf = 1'b0;
        step_bytes.push_back(ob);
      end
    end
    foreach (step_bytes[i]) bytes_due.push_back(step_bytes[i]);
  endtask

  function automatic logic [7:0] rand_blank();
    if ($urandom_range(1) == 0) return 8'($urandom_range(32, 0));
    return 8'($urandom_range(255, 128));
  endfunction

  function automatic logic [LN_W-1:0] rand_line_no();
    case ($urandom_range(3))
      0: return LN_W'($urandom_range(999, 0));
      1: return LN_W'($urandom);
      2: return LN_W'($urandom_range(100000005, 99999990));
      default: return LN_W'($urandom_range(9, 0));
    endcase
  endfunction

  task automatic random_line();
    int pick;
    logic [7:0] c;
    repeat ($urandom_range(12, 0)) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        c = 8'($urandom_range(8'h7E, 8'h21));
        if (c == CH_SEMI) c = "G";
        issue(CMD_BYTE, c, LN_W'($urandom), 1'b0, 0, '0);
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1)) issue(CMD_BYTE, rand_blank(), LN_W'($urandom), 1'b0, 0, '0);
      end else if (pick < 83) begin
        // long blank run, may spill past the store
        repeat ($urandom_range(38, 30))
          issue(CMD_BYTE, rand_blank(), LN_W'($urandom), 1'b0, 0, '0);
      end else if (pick < 88) begin
        issue(CMD_LOAD, 8'($urandom), rand_line_no(), 1'b0, 0, '0);
      end else if (pick < 91) begin
        issue(CMD_NONE, 8'($urandom), LN_W'($urandom), 1'b0, 0, '0);
      end else if (pick < 94) begin
        issue(CMD_BYTE, CH_SEMI, LN_W'($urandom), 1'b0, 0, '0);
        repeat ($urandom_range(3, 0)) issue(CMD_BYTE, 8'($urandom), LN_W'($urandom), 1'b0, 0, '0);
      end else begin
        issue(CMD_BYTE, 8'($urandom), LN_W'($urandom), 1'b0, 0, '0);
      end
    end
    issue(CMD_EOL, 8'($urandom), LN_W'($urandom), 1'b0, 0, '0);
  endtask

  task automatic drain_pause();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (bytes_due.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    out_byte_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got byte %h last %b ovf %b",
                 $time, m_tdata, m_tlast, m_tuser);
      end else begin
        want = bytes_due.pop_front();
        if (m_tdata != want.ch) begin
          errors++;
          $display("%0t: out_byte expected %h got %h", $time, want.ch, m_tdata);
        end
        if (m_tlast != want.last) begin
          errors++;
          $display("%0t: last expected %b got %b", $time, want.last, m_tlast);
        end
        if (m_tuser != want.ovf) begin
          errors++;
          $display("%0t: space_overflow expected %b got %b", $time, want.ovf, m_tuser);
        end
      end
    end
  end

  initial begin
    while (cycles < TIMEOUT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (stim_rows[r]) begin
      repeat (stim_rows[r].reps)
        issue(stim_rows[r].cmd,
              stim_rows[r].cmd == CMD_BYTE ? stim_rows[r].ch : 8'($urandom),
              stim_rows[r].cmd == CMD_LOAD ? stim_rows[r].ln : LN_W'($urandom),
              stim_rows[r].gold_en, int'(stim_rows[r].n_gold), stim_rows[r].gold);
    end
    items_done = 0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 30;
          snk_idle_pct = 71;
        end
        1: begin
          src_idle_pct = 71;
          snk_idle_pct = 30;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      drain_pause();
      while (items_done < RAND_ITEMS * (ph + 1) / 3) random_line();
    end
    drain_pause();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && bytes_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/glf_pkg.sv
rtl/gcode_line_framer_core.sv
dv/gcode_line_framer_core_tb.sv
